// File: src/ptwa_pkg.sv
// Shared types, codes and helpers of the peer table with aging.
package ptwa_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int IDX_SPAN    = 16;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_RECV = 2'd1,
    CMD_AGE  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_RANGE = 3'd2,
    ST_STALE = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  typedef struct packed {
    logic        vld;
    cmd_t        cmd;
    logic [47:0] mac;
    logic [63:0] now;
    logic [3:0]  idx;
    logic        hit;
    logic        app;
    logic [4:0]  nrep;
    logic [4:0]  rid;
    logic [47:0] rmac;
    logic        ract;
    logic [63:0] rseen;
  } tok_t;

  typedef struct packed {
    logic        vld;
    status_t     status;
    logic [4:0]  id;
    logic [47:0] mac;
    logic        act;
    logic [63:0] seen;
  } res_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  id;
    logic [47:0] mac;
    logic        act;
    logic [63:0] seen;
    logic [4:0]  used;
    logic        last;
  } out_t;

  function automatic out_t pack_res(res_t r, logic [4:0] used, logic last);
    out_t o;
    o.status = r.status;
    o.id     = r.id;
    o.mac    = r.mac;
    o.act    = r.act;
    o.seen   = r.seen;
    o.used   = used;
    o.last   = last;
    return o;
  endfunction

endpackage

// File: src/ptwa_cell.sv
// One table slot: holds a peer entry and passes the transaction token to the next slot.
module ptwa_cell import ptwa_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [31:0] timeout,
  input  tok_t        tok_i,
  output tok_t        tok_o,
  output res_t        emit_o
);

  localparam logic [4:0] ID     = 5'((IDX + 1) % 32);
  localparam logic [3:0] RD_IDX = 4'(IDX % IDX_SPAN);
  localparam bit         RD_OK  = IDX < IDX_SPAN;

  logic        used_r, used_nxt;
  logic        act_r, act_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [63:0] seen_r, seen_nxt;
  tok_t        tok_r, tok_nxt;
  logic [63:0] age;
  logic        stale;

  always_comb begin
    tok_nxt  = tok_i;
    used_nxt = used_r;
    act_nxt  = act_r;
    mac_nxt  = mac_r;
    seen_nxt = seen_r;
    emit_o   = '0;
    age      = tok_i.now - seen_r;
    stale    = age >= {32'd0, timeout};
    if (tok_i.vld) begin
      unique case (tok_i.cmd)
        CMD_ADD, CMD_RECV: begin
          if (!tok_i.hit && (!used_r || mac_r == tok_i.mac)) begin
            if (!used_r) begin
              used_nxt    = 1'b1;
              mac_nxt     = tok_i.mac;
              seen_nxt    = tok_i.now;
              tok_nxt.app = 1'b1;
            end
            act_nxt = 1'b1;
            if (tok_i.cmd == CMD_RECV) begin
              seen_nxt = tok_i.now;
            end
            tok_nxt.hit   = 1'b1;
            tok_nxt.rid   = ID;
            tok_nxt.rmac  = mac_nxt;
            tok_nxt.ract  = 1'b1;
            tok_nxt.rseen = seen_nxt;
          end
        end
        CMD_AGE: begin
          if (used_r && act_r && stale) begin
            act_nxt = 1'b0;
            if (tok_i.nrep < 5'(MAX_RESULTS)) begin
              emit_o.vld    = 1'b1;
              emit_o.status = ST_STALE;
              emit_o.id     = ID;
              emit_o.mac    = mac_r;
              emit_o.act    = 1'b0;
              emit_o.seen   = seen_r;
              tok_nxt.nrep  = tok_i.nrep + 5'd1;
            end
          end
        end
        CMD_READ: begin
          if (RD_OK && used_r && tok_i.idx == RD_IDX) begin
            tok_nxt.hit   = 1'b1;
            tok_nxt.rid   = ID;
            tok_nxt.rmac  = mac_r;
            tok_nxt.ract  = act_r;
            tok_nxt.rseen = seen_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      act_r  <= 1'b0;
      tok_r  <= '0;
    end else if (adv) begin
      used_r <= used_nxt;
      act_r  <= act_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mac_r  <= mac_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: src/peer_table_with_aging_core.sv
// Top level of the peer table with aging: token entry, slot chain and result staging.
//
// Peer table with aging, up to PEER_SLOTS peers keyed by 48-bit MAC. Each
// transaction is carried as a token through a chain of slot cells, one slot
// per cycle while the result side does not stall the chain. The token enters
// the entry register, passes through the register of each slot cell in turn,
// and its final result is then loaded into the output register; the next
// item can be accepted once that result has been loaded. One item is
// in flight at a time and in_stall is high until its last result has been
// loaded into the output register. An aging sweep reports each stale peer in
// slot order (at most 16 reports) and flags the final result of each item
// with out_last_of_run. Write cfg_wdata to set the stale timeout in
// microseconds only while idle.
module peer_table_with_aging_core import ptwa_pkg::*; #(
  parameter int PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [47:0] in_peer_mac,
  input  logic [63:0] in_now_us,
  input  logic [3:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_peer_id,
  output logic [47:0] out_entry_mac,
  output logic        out_entry_active,
  output logic [63:0] out_entry_last_seen,
  output logic [4:0]  out_entries_used,
  output logic        out_last_of_run
);

  localparam int CW = $clog2(PEER_SLOTS + 1);

  logic [31:0]     to_r;
  logic            busy_r, busy_nxt;
  tok_t            entry_r, entry_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  res_t            pend_r, pend_nxt;
  out_t            out_r, out_nxt;
  logic            out_vld_r, out_vld_nxt;
  tok_t            tok_w [0:PEER_SLOTS];
  res_t            emit_w [0:PEER_SLOTS-1];
  res_t            emit_or;
  res_t            fin;
  tok_t            ex;
  logic [PEER_SLOTS:0] tok_vld;
  logic            out_free, exit_vld, need_out, adv, accept;
  logic [CW+4:0]   fill_cur_ext, fill_new_ext;

  assign tok_w[0] = entry_r;

  for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_slot
    ptwa_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .timeout (to_r),
      .tok_i   (tok_w[i]),
      .tok_o   (tok_w[i+1]),
      .emit_o  (emit_w[i])
    );
  end

  always_comb begin
    emit_or = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      emit_or = res_t'(emit_or | emit_w[i]);
    end
    for (int i = 0; i <= PEER_SLOTS; i++) begin
      tok_vld[i] = tok_w[i].vld;
    end
  end

  assign accept   = in_valid && !busy_r;
  assign ex       = tok_w[PEER_SLOTS];
  assign exit_vld = ex.vld;
  assign out_free = !out_vld_r || !out_stall;
  assign need_out = exit_vld || (emit_or.vld && pend_r.vld);
  assign adv      = out_free || !need_out;

  always_comb begin
    entry_nxt = entry_r;
    if (accept) begin
      entry_nxt     = '0;
      entry_nxt.vld = 1'b1;
      entry_nxt.cmd = cmd_t'(in_cmd);
      entry_nxt.mac = in_peer_mac;
      entry_nxt.now = in_now_us;
      entry_nxt.idx = in_read_index;
    end else if (adv) begin
      entry_nxt.vld = 1'b0;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (exit_vld && adv) begin
      fill_nxt = fill_r + CW'(ex.app);
    end
    fill_cur_ext = {5'd0, fill_r};
    fill_new_ext = {5'd0, fill_nxt};

    fin = '0;
    unique case (ex.cmd)
      CMD_ADD, CMD_RECV, CMD_READ: begin
        if (ex.hit) begin
          fin.status = ST_OK;
          fin.id     = ex.rid;
          fin.mac    = ex.rmac;
          fin.act    = ex.ract;
          fin.seen   = ex.rseen;
        end else begin
          fin.status = (ex.cmd == CMD_READ) ? ST_RANGE : ST_FULL;
        end
      end
      CMD_AGE: begin
        if (pend_r.vld) begin
          fin = pend_r;
        end else begin
          fin.status = ST_NONE;
        end
      end
    endcase

    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && out_stall;
    pend_nxt    = pend_r;
    busy_nxt    = busy_r;
    if (adv) begin
      if (emit_or.vld) begin
        if (pend_r.vld) begin
          out_nxt     = pack_res(pend_r, fill_cur_ext[4:0], 1'b0);
          out_vld_nxt = 1'b1;
        end
        pend_nxt = emit_or;
      end
      if (exit_vld) begin
        out_nxt      = pack_res(fin, fill_new_ext[4:0], 1'b1);
        out_vld_nxt  = 1'b1;
        pend_nxt.vld = 1'b0;
        busy_nxt     = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_r      <= 32'd5000000;
      busy_r    <= 1'b0;
      entry_r   <= '0;
      fill_r    <= '0;
      pend_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        to_r <= cfg_wdata;
      end
      busy_r    <= busy_nxt;
      fill_r    <= fill_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
      entry_r   <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign in_stall            = busy_r;
  assign out_valid           = out_vld_r;
  assign out_status          = out_r.status;
  assign out_peer_id         = out_r.id;
  assign out_entry_mac       = out_r.mac;
  assign out_entry_active    = out_r.act;
  assign out_entry_last_seen = out_r.seen;
  assign out_entries_used    = out_r.used;
  assign out_last_of_run     = out_r.last;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_vld))
    else $error("more than one token in the slot chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_vld == '0 && !pend_r.vld))
    else $error("token or pending report present while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(PEER_SLOTS))
    else $error("fill count beyond table size");

  a_pend_age: assert property (@(posedge clk) disable iff (!rst_n)
    emit_or.vld |-> $countones(tok_vld) == 1)
    else $error("stale report without a token in flight");

endmodule

// File: bench/tb.sv
// Testbench of the peer table with aging: directed table, then randomised traffic checked by a predictor.
`timescale 1ns / 1ps
module tb import ptwa_pkg::*; ();

  localparam int SLOTS = 16;

  typedef struct {
    cmd_t        cmd;
    logic [47:0] mac;
    logic [63:0] now;
    logic [3:0]  idx;
    bit          typed;
    out_t        want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [47:0] in_peer_mac;
  logic [63:0] in_now_us;
  logic [3:0]  in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [4:0]  out_peer_id;
  logic [47:0] out_entry_mac;
  logic        out_entry_active;
  logic [63:0] out_entry_last_seen;
  logic [4:0]  out_entries_used;
  logic        out_last_of_run;

  logic [47:0] tbl_mac [SLOTS];
  logic        tbl_act [SLOTS];
  logic [63:0] tbl_seen[SLOTS];
  int          tbl_fill;
  logic [31:0] age_limit;

  out_t step_reports[$];
  out_t owed_reports[$];
  row_t rows[$];
  out_t got;
  out_t want;
  int   mismatches = 0;
  int   rx_hold = 0;
  bit   calm = 1'b0;

  peer_table_with_aging_core #(
    .PEER_SLOTS(SLOTS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_peer_mac         (in_peer_mac),
    .in_now_us           (in_now_us),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_peer_id         (out_peer_id),
    .out_entry_mac       (out_entry_mac),
    .out_entry_active    (out_entry_active),
    .out_entry_last_seen (out_entry_last_seen),
    .out_entries_used    (out_entries_used),
    .out_last_of_run     (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic out_t report(status_t s, int slot, logic last);
    out_t r;
    r = '0;
    r.status = s;
    if (slot >= 0) begin
      r.id   = 5'(slot + 1);
      r.mac  = tbl_mac[slot];
      r.act  = tbl_act[slot];
      r.seen = tbl_seen[slot];
    end
    r.used = 5'(tbl_fill);
    r.last = last;
    return r;
  endfunction

  function automatic void table_step(cmd_t c, logic [47:0] m, logic [63:0] t, logic [3:0] ix);
    int   slot;
    int   hits;
    out_t tail;
    step_reports.delete();
    slot = -1;
    hits = 0;
    case (c)
      CMD_ADD, CMD_RECV: begin
        for (int i = 0; i < tbl_fill; i++)
          if (slot < 0 && tbl_mac[i] == m) slot = i;
        if (slot < 0 && tbl_fill < SLOTS) begin
          slot = tbl_fill;
          tbl_mac[slot]  = m;
          tbl_seen[slot] = t;
          tbl_fill++;
        end
        if (slot < 0) begin
          step_reports.push_back(report(ST_FULL, -1, 1'b1));
        end else begin
          tbl_act[slot] = 1'b1;
          if (c == CMD_RECV) tbl_seen[slot] = t;
          step_reports.push_back(report(ST_OK, slot, 1'b1));
        end
      end
      CMD_AGE: begin
        for (int i = 0; i < tbl_fill; i++)
          if (tbl_act[i] && (t - tbl_seen[i]) >= {32'd0, age_limit}) begin
            tbl_act[i] = 1'b0;
            if (hits < MAX_RESULTS) step_reports.push_back(report(ST_STALE, i, 1'b0));
            hits++;
          end
        if (hits == 0) begin
          step_reports.push_back(report(ST_NONE, -1, 1'b1));
        end else begin
          tail = step_reports.pop_back();
          tail.last = 1'b1;
          step_reports.push_back(tail);
        end
      end
      default: begin
        if (int'(ix) < tbl_fill) step_reports.push_back(report(ST_OK, int'(ix), 1'b1));
        else step_reports.push_back(report(ST_RANGE, -1, 1'b1));
      end
    endcase
  endfunction

  function automatic row_t row(cmd_t c, logic [47:0] m, logic [63:0] t, logic [3:0] ix);
    row_t r;
    r.cmd   = c;
    r.mac   = m;
    r.now   = t;
    r.idx   = ix;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t row_want(cmd_t c, logic [47:0] m, logic [63:0] t, logic [3:0] ix,
                                    status_t s, logic [4:0] id, logic [47:0] em, logic ea,
                                    logic [63:0] es, logic [4:0] used);
    row_t r;
    r = row(c, m, t, ix);
    r.typed = 1'b1;
    r.want  = '{status: s, id: id, mac: em, act: ea, seen: es, used: used, last: 1'b1};
    return r;
  endfunction

  task automatic flag(string what, out_t g, out_t w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: status exp %0d act %0d, id exp %0d act %0d, mac exp %h act %h",
               $time, what, w.status, g.status, w.id, g.id, w.mac, g.mac);
      $display("  active exp %0d act %0d, seen exp %h act %h, used exp %0d act %0d, last %0d/%0d",
               w.act, g.act, w.seen, g.seen, w.used, g.used, w.last, g.last);
    end
  endtask

  task automatic offer(row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= r.cmd;
    in_peer_mac   <= r.mac;
    in_now_us     <= r.now;
    in_read_index <= r.idx;
    // hold the payload until the transaction is taken
    do @(posedge clk); while (in_stall !== 1'b0);
    table_step(r.cmd, r.mac, r.now, r.idx);
    if (r.typed) owed_reports.push_back(r.want);
    else foreach (step_reports[k]) owed_reports.push_back(step_reports[k]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    age_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int n;
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 5);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1 || rst_n !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.status = status_t'(out_status);
      got.id     = out_peer_id;
      got.mac    = out_entry_mac;
      got.act    = out_entry_active;
      got.seen   = out_entry_last_seen;
      got.used   = out_entries_used;
      got.last   = out_last_of_run;
      if (owed_reports.size() == 0) begin
        flag("result with nothing owed", got, '0);
      end else begin
        want = owed_reports.pop_front();
        if (got.status !== want.status || got.id !== want.id || got.mac !== want.mac ||
            got.act !== want.act || got.seen !== want.seen || got.used !== want.used ||
            got.last !== want.last)
          flag("mismatch", got, want);
      end
    end
  end

  initial begin : stimulus
    row_t        r;
    logic [63:0] clock_us;
    logic [63:0] step;
    logic [31:0] v;
    int          pick;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_ADD;
    in_peer_mac   <= '0;
    in_now_us     <= '0;
    in_read_index <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_mac[i]  = '0;
      tbl_act[i]  = 1'b0;
      tbl_seen[i] = '0;
    end
    tbl_fill  = 0;
    age_limit = 32'd5_000_000;
    clock_us  = 64'hFFFF_FFFF_FF00_0000;

    rows.push_back(row_want(CMD_READ, '0, '0, 4'd0, ST_RANGE, 5'd0, '0, 1'b0, '0, 5'd0));
    rows.push_back(row_want(CMD_AGE, '0, '0, 4'd0, ST_NONE, 5'd0, '0, 1'b0, '0, 5'd0));
    rows.push_back(row_want(CMD_ADD, '0, '0, 4'd0, ST_OK, 5'd1, '0, 1'b1, '0, 5'd1));
    rows.push_back(row_want(CMD_RECV, '1, '1, 4'd15, ST_OK, 5'd2, '1, 1'b1, '1, 5'd2));
    rows.push_back(row_want(CMD_ADD, '0, 64'd77, 4'd7, ST_OK, 5'd1, '0, 1'b1, '0, 5'd2));
    rows.push_back(row_want(CMD_READ, '1, '0, 4'd1, ST_OK, 5'd2, '1, 1'b1, '1, 5'd2));
    rows.push_back(row_want(CMD_READ, '0, '1, 4'd15, ST_RANGE, 5'd0, '0, 1'b0, '0, 5'd2));
    rows.push_back(row(CMD_AGE, '0, 64'd0, 4'd0));
    rows.push_back(row(CMD_AGE, '0, 64'd5_000_000, 4'd0));
    rows.push_back(row(CMD_RECV, '0, 64'd10, 4'd0));
    for (int k = 0; k < 14; k++)
      rows.push_back(row(k % 2 ? CMD_RECV : CMD_ADD, {4'(k + 1), 44'h0A5_F0C3_3C96},
                         64'd5_000_000 + 64'(k) * 64'd1000, 4'(k)));
    rows.push_back(row_want(CMD_ADD, 48'h8000_0000_0001, 64'd42, 4'd0,
                            ST_FULL, 5'd0, '0, 1'b0, '0, 5'd16));
    rows.push_back(row_want(CMD_RECV, 48'h7FFF_FFFF_FFFE, '1, 4'd0,
                            ST_FULL, 5'd0, '0, 1'b0, '0, 5'd16));
    rows.push_back(row(CMD_RECV, '1, 64'd123, 4'd0));
    rows.push_back(row(CMD_AGE, '0, '1, 4'd0));
    rows.push_back(row(CMD_READ, '0, '0, 4'd15));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) offer(rows[i]);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: v = 32'd1;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'd1000;
        3: v = 32'($urandom_range(1, 1 << 20));
        4: v = 32'd5_000_000;
        default: begin
          v = $urandom;
          if (v == 0) v = 32'd1;
        end
      endcase
      write_limit(v);
      calm = (p == 2);
      if (p == 3) rx_hold = 300;
      for (int k = 0; k < 75; k++) begin
        if (p == 4 && k == 38) drain();
        pick = $urandom_range(0, 9);
        r.cmd = pick < 2 ? CMD_ADD : pick < 6 ? CMD_RECV : pick < 8 ? CMD_AGE : CMD_READ;
        if ($urandom_range(0, 4) == 0) r.mac = {16'($urandom), $urandom};
        else r.mac = tbl_mac[$urandom_range(0, tbl_fill - 1)];
        if ($urandom_range(0, 7) == 0) begin
          r.now = {$urandom, $urandom};
        end else begin
          step     = {$urandom, $urandom} % ({32'd0, age_limit} * 64'd2 + 64'd1);
          clock_us = clock_us + step;
          r.now    = clock_us;
        end
        r.idx   = 4'($urandom);
        r.typed = 1'b0;
        r.want  = '0;
        offer(r);
      end
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 50000 && owed_reports.size() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    mismatches += owed_reports.size();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
